@@ hdl/assert_macros.svh @@
// Shared assertion macros; clk and rst_n are taken from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Implication checked at every edge outside reset
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/eia_pkg.sv @@
package eia_pkg;

  localparam int VW = 32;
  localparam int DIV_STEPS = VW;
  localparam int QDEPTH = 4;

  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // operand and result kinds
  localparam logic [1:0] KIND_FIN = 2'd0;
  localparam logic [1:0] KIND_POS = 2'd1;
  localparam logic [1:0] KIND_NEG = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  // commands
  localparam logic [3:0] CMD_ADD = 4'd0;
  localparam logic [3:0] CMD_SUB = 4'd1;
  localparam logic [3:0] CMD_MUL = 4'd2;
  localparam logic [3:0] CMD_DIV = 4'd3;
  localparam logic [3:0] CMD_REM = 4'd4;
  localparam logic [3:0] CMD_NEG = 4'd5;
  localparam logic [3:0] CMD_INC = 4'd6;
  localparam logic [3:0] CMD_DEC = 4'd7;
  localparam logic [3:0] CMD_CMP = 4'd8;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_INDET = 2'd1;
  localparam logic [1:0] ERR_DIVZ  = 2'd2;

  typedef enum logic [1:0] {
    OP_DIRECT,
    OP_MUL,
    OP_DIV,
    OP_REM
  } op_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [VW-1:0] value;
    logic [1:0]    err;
    logic          ord;
    logic          lt;
    logic          eq;
    logic          gt;
  } result_t;

  typedef struct packed {
    op_t           op;
    logic          neg;
    logic [VW-1:0] mag_a;
    logic [VW-1:0] mag_b;
    result_t       res;
  } work_t;

endpackage

@@ hdl/eia_front.sv @@
module eia_front (
  input  logic [3:0]          command,
  input  logic [1:0]          a_kind,
  input  logic [eia_pkg::VW-1:0] a_value,
  input  logic [1:0]          b_kind,
  input  logic [eia_pkg::VW-1:0] b_value,
  output eia_pkg::work_t      work
);
  import eia_pkg::*;

  logic          a_fin, b_fin, a_zero, b_zero, a_sn, b_sn, a_ng, b_ng;
  logic [VW-1:0] a_mag, b_mag;
  logic [VW:0]   sum, dif;
  logic          inf_neg;

  assign a_fin  = (a_kind == KIND_FIN);
  assign b_fin  = (b_kind == KIND_FIN);
  assign a_zero = (a_value == '0);
  assign b_zero = (b_value == '0);
  assign a_sn   = a_value[VW-1];
  assign b_sn   = b_value[VW-1];
  assign a_mag  = a_sn ? (~a_value + 1'b1) : a_value;
  assign b_mag  = b_sn ? (~b_value + 1'b1) : b_value;
  assign sum    = {a_sn, a_value} + {b_sn, b_value};
  assign dif    = {a_sn, a_value} - {b_sn, b_value};
  // sign of each operand, infinities included
  assign a_ng   = (a_kind == KIND_NEG) || (a_fin && a_sn);
  assign b_ng   = (b_kind == KIND_NEG) || (b_fin && b_sn);
  assign inf_neg = a_ng ^ b_ng;

  function automatic result_t mk(input logic [1:0] k, input logic [VW-1:0] v);
    result_t r;
    r = '0;
    r.kind  = k;
    r.value = (k == KIND_POS) ? VMAX : (k == KIND_NEG) ? VMIN : v;
    return r;
  endfunction

  function automatic result_t fail(input logic [1:0] e);
    result_t r;
    r = '0;
    r.err = e;
    return r;
  endfunction

  function automatic logic [1:0] flip(input logic [1:0] k);
    return (k == KIND_POS) ? KIND_NEG : KIND_POS;
  endfunction

  // classify the request: settle everything but the long arithmetic here
  always_comb begin
    work       = '0;
    work.op    = OP_DIRECT;
    work.mag_a = a_mag;
    work.mag_b = b_mag;
    if ((command <= CMD_REM) && (a_kind == KIND_BAD || b_kind == KIND_BAD)) begin
      work.res = fail(ERR_INDET);
    end else if ((command >= CMD_NEG) && (command <= CMD_DEC) && (a_kind == KIND_BAD)) begin
      work.res = fail(ERR_INDET);
    end else begin
      unique case (command)
        CMD_ADD: begin
          if (!a_fin && !b_fin) work.res = (a_kind == b_kind) ? mk(a_kind, '0) : fail(ERR_INDET);
          else if (!a_fin) work.res = mk(a_kind, '0);
          else if (!b_fin) work.res = mk(b_kind, '0);
          else if (sum[VW] != sum[VW-1]) work.res = mk(sum[VW] ? KIND_NEG : KIND_POS, '0);
          else work.res = mk(KIND_FIN, sum[VW-1:0]);
        end
        CMD_SUB: begin
          if (!a_fin && !b_fin) work.res = (a_kind != b_kind) ? mk(a_kind, '0) : fail(ERR_INDET);
          else if (!a_fin) work.res = mk(a_kind, '0);
          else if (!b_fin) work.res = mk(flip(b_kind), '0);
          else if (dif[VW] != dif[VW-1]) work.res = mk(dif[VW] ? KIND_NEG : KIND_POS, '0);
          else work.res = mk(KIND_FIN, dif[VW-1:0]);
        end
        CMD_MUL: begin
          if (!a_fin || !b_fin) begin
            if ((a_fin && a_zero) || (b_fin && b_zero)) work.res = fail(ERR_INDET);
            else work.res = mk(inf_neg ? KIND_NEG : KIND_POS, '0);
          end else begin
            work.op  = OP_MUL;
            work.neg = a_sn ^ b_sn;
          end
        end
        CMD_DIV: begin
          if (b_fin && b_zero) work.res = fail(ERR_DIVZ);
          else if (!a_fin) begin
            if (!b_fin) work.res = fail(ERR_INDET);
            else work.res = mk(inf_neg ? KIND_NEG : KIND_POS, '0);
          end else if (a_zero || !b_fin) work.res = mk(KIND_FIN, '0);
          else begin
            work.op  = OP_DIV;
            work.neg = a_sn ^ b_sn;
          end
        end
        CMD_REM: begin
          if (b_fin && b_zero) work.res = fail(ERR_DIVZ);
          else if (a_fin && a_zero) work.res = mk(KIND_FIN, '0);
          else if (a_fin && !b_fin) work.res = mk(KIND_FIN, a_value);
          else if (b_fin && b_mag == {{(VW-1){1'b0}}, 1'b1}) work.res = mk(KIND_FIN, '0);
          else if (!a_fin) work.res = fail(ERR_INDET);
          else begin
            work.op  = OP_REM;
            work.neg = a_sn;
          end
        end
        CMD_NEG: begin
          if (!a_fin) work.res = mk(flip(a_kind), '0);
          else if (a_value == VMIN) work.res = mk(KIND_POS, '0);
          else work.res = mk(KIND_FIN, ~a_value + 1'b1);
        end
        CMD_INC: begin
          if (!a_fin) work.res = mk(a_kind, '0);
          else if (a_value == VMAX) work.res = mk(KIND_POS, '0);
          else work.res = mk(KIND_FIN, a_value + 1'b1);
        end
        CMD_DEC: begin
          if (!a_fin) work.res = mk(a_kind, '0);
          else if (a_value == VMIN) work.res = mk(KIND_NEG, '0);
          else work.res = mk(KIND_FIN, a_value - 1'b1);
        end
        CMD_CMP: begin
          if (a_fin && b_fin) begin
            work.res.ord = 1'b1;
            work.res.lt  = $signed(a_value) <  $signed(b_value);
            work.res.eq  = a_value == b_value;
            work.res.gt  = $signed(a_value) >  $signed(b_value);
          end
        end
        default: work.res = '0;
      endcase
    end
  end

endmodule

@@ hdl/eia_queue.sv @@
`include "assert_macros.svh"

module eia_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  eia_pkg::work_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output eia_pkg::work_t  head_data
);
  import eia_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  work_t         mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == QDEPTH[PW:0]);
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= QDEPTH[PW:0])
  `ASSERT_IMPLY(a_ptr_gap, cnt_r == '0, wr_ptr_r == rd_ptr_r)

endmodule

@@ hdl/eia_back.sv @@
`include "assert_macros.svh"

module eia_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  eia_pkg::work_t         q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output eia_pkg::result_t       out_res
);
  import eia_pkg::*;

  localparam int N = DIV_STEPS;

  logic          en;
  logic [N:0]    vld_r;
  op_t           op_r  [N+1];
  logic          neg_r [N+1];
  logic [VW-1:0] rem_r [N+1];
  logic [VW-1:0] quo_r [N+1];
  logic [VW-1:0] dvs_r [N+1];
  result_t       res_r [N+1];
  logic [2*VW-1:0] prod;
  logic          out_vld_r;
  result_t       out_r, fin_nxt;
  logic [2:0]    flags;

  // the whole pipeline moves together unless the output is held
  assign en        = !out_vld_r || out_ready;
  assign q_pop     = en && q_valid;
  assign out_valid = out_vld_r;
  assign out_res   = out_r;
  assign prod      = q_data.mag_a * q_data.mag_b;

  // entry stage: load operands, multiply into the remainder/quotient pair
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (en) vld_r[0] <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0]  <= q_data.op;
      neg_r[0] <= q_data.neg;
      res_r[0] <= q_data.res;
      dvs_r[0] <= q_data.mag_b;
      if (q_data.op == OP_MUL) begin
        rem_r[0] <= prod[2*VW-1:VW];
        quo_r[0] <= prod[VW-1:0];
      end else begin
        rem_r[0] <= '0;
        quo_r[0] <= q_data.mag_a;
      end
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar s = 0; s < N; s++) begin : g_step
    logic [VW:0] sh, dif;
    logic        is_div;

    assign sh     = {rem_r[s], quo_r[s][VW-1]};
    assign dif    = sh - {1'b0, dvs_r[s]};
    assign is_div = (op_r[s] == OP_DIV) || (op_r[s] == OP_REM);

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s+1] <= 1'b0;
      else if (en) vld_r[s+1] <= vld_r[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op_r[s+1]  <= op_r[s];
        neg_r[s+1] <= neg_r[s];
        res_r[s+1] <= res_r[s];
        dvs_r[s+1] <= dvs_r[s];
        if (is_div) begin
          rem_r[s+1] <= dif[VW] ? sh[VW-1:0] : dif[VW-1:0];
          quo_r[s+1] <= {quo_r[s][VW-2:0], ~dif[VW]};
        end else begin
          rem_r[s+1] <= rem_r[s];
          quo_r[s+1] <= quo_r[s];
        end
      end
    end
  end

  // apply sign and saturation to the finished magnitude
  always_comb begin
    fin_nxt = res_r[N];
    unique case (op_r[N])
      OP_MUL: begin
        fin_nxt = '0;
        if (neg_r[N]) begin
          if (rem_r[N] != '0 || quo_r[N] > VMIN) begin
            fin_nxt.kind = KIND_NEG; fin_nxt.value = VMIN;
          end else fin_nxt.value = ~quo_r[N] + 1'b1;
        end else begin
          if (rem_r[N] != '0 || quo_r[N][VW-1]) begin
            fin_nxt.kind = KIND_POS; fin_nxt.value = VMAX;
          end else fin_nxt.value = quo_r[N];
        end
      end
      OP_DIV: begin
        fin_nxt = '0;
        if (neg_r[N]) fin_nxt.value = ~quo_r[N] + 1'b1;
        else if (quo_r[N][VW-1]) begin
          fin_nxt.kind = KIND_POS; fin_nxt.value = VMAX;
        end else fin_nxt.value = quo_r[N];
      end
      OP_REM: begin
        fin_nxt = '0;
        fin_nxt.value = neg_r[N] ? (~rem_r[N] + 1'b1) : rem_r[N];
      end
      default: fin_nxt = res_r[N];
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= vld_r[N];
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= fin_nxt;
  end

  assign flags = {out_r.lt, out_r.eq, out_r.gt};

  `ASSERT_IMPLY(a_err_clean, out_vld_r && out_r.err != ERR_NONE,
                out_r.kind == KIND_FIN && out_r.value == '0)
  `ASSERT_IMPLY(a_cmp_onehot, out_vld_r && out_r.ord, $onehot(flags))
  `ASSERT_IMPLY(a_cmp_clear, out_vld_r && !out_r.ord, flags == 3'b000)

endmodule

@@ hdl/extended_integer_alu.sv @@
// Signed 32-bit integer ALU whose operands and result carry a kind tag
// (finite, +Inf, -Inf), with saturation to infinity and error codes.
// Input channel in_*: in_tuser holds command and the two operand kinds,
// in_tdata the two operand values. Output channel out_*: out_tuser holds
// result kind and error code, out_tdata the result value and compare flags.
// The front end classifies each request in the cycle it is accepted and
// resolves every case except finite multiply, divide and remainder; the
// back end is a 34-stage pipeline (multiplier at entry, then a restoring
// divider producing one quotient bit per stage, then a sign/saturate stage).
// Throughput is one request per cycle while out_tready stays high. A
// four-entry queue sits between front and back.
// When out_tready is low the back pipeline holds as a whole; the queue keeps
// accepting until full, then in_tready drops. Synchronous reset empties the
// queue and the pipeline; there is no other state.
module extended_integer_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // a_value[31:0], b_value[63:32]
  input  logic [7:0]  in_tuser,   // command[3:0], a_kind[5:4], b_kind[7:6]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_value[31:0], ordered, less, equal, greater, zero pad
  output logic [3:0]  out_tuser   // result_kind[1:0], error_code[3:2]
);
  import eia_pkg::*;

  work_t   fr_work, q_head;
  logic    q_full, q_valid, q_pop;
  result_t res;

  eia_front u_front (
    .command (in_tuser[3:0]),
    .a_kind  (in_tuser[5:4]),
    .a_value (in_tdata[31:0]),
    .b_kind  (in_tuser[7:6]),
    .b_value (in_tdata[63:32]),
    .work    (fr_work)
  );

  assign in_tready = !q_full;

  eia_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid),
    .push_data  (fr_work),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  eia_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // pack the result
  assign out_tdata = {4'b0000, res.gt, res.eq, res.lt, res.ord, res.value};
  assign out_tuser = {res.err, res.kind};

endmodule

@@ sim/extended_integer_alu_tb.sv @@
module extended_integer_alu_tb;
  import eia_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [1:0]  err;
    logic        ord;
    logic        lt;
    logic        eq;
    logic        gt;
  } alu_result_t;

  typedef struct {
    logic [3:0]  cmd;
    logic [1:0]  ak;
    logic [31:0] av;
    logic [1:0]  bk;
    logic [31:0] bv;
    bit          known;
    alu_result_t res;
  } alu_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [7:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;

  alu_result_t expected_q[$];
  alu_row_t    rows[$];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          recv_hold;

  extended_integer_alu u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Build a result of the given kind; infinities carry the saturated value
  function automatic alu_result_t make_res(logic [1:0] kind, logic [31:0] v);
    alu_result_t r;
    r = '{default: '0};
    r.kind  = kind;
    r.value = (kind == KIND_POS) ? VMAX : (kind == KIND_NEG) ? VMIN : v;
    return r;
  endfunction

  function automatic alu_result_t make_err(logic [1:0] e);
    alu_result_t r;
    r = '{default: '0};
    r.err = e;
    return r;
  endfunction

  function automatic bit is_neg(logic [1:0] k, longint v);
    return k == KIND_NEG || (k == KIND_FIN && v < 0);
  endfunction

  // Saturate an exact finite result into the 32-bit range
  function automatic alu_result_t clamp(longint x);
    if (x > longint'(32'sh7fffffff)) return make_res(KIND_POS, '0);
    if (x < -longint'(64'sh80000000)) return make_res(KIND_NEG, '0);
    return make_res(KIND_FIN, x[31:0]);
  endfunction

  // Compute the expected result of one request
  function automatic alu_result_t alu_predict(logic [3:0] cmd, logic [1:0] ak,
                                              logic [31:0] av, logic [1:0] bk,
                                              logic [31:0] bv);
    alu_result_t r;
    longint a, b;
    bit af, bf;
    a  = longint'(signed'(av));
    b  = longint'(signed'(bv));
    af = ak == KIND_FIN;
    bf = bk == KIND_FIN;
    r  = make_err(ERR_NONE);
    if (cmd <= CMD_REM && (ak == KIND_BAD || bk == KIND_BAD)) return make_err(ERR_INDET);
    if (cmd >= CMD_NEG && cmd <= CMD_DEC && ak == KIND_BAD) return make_err(ERR_INDET);
    case (cmd)
      CMD_ADD: begin
        if (!af && !bf) r = (ak == bk) ? make_res(ak, '0) : make_err(ERR_INDET);
        else if (!af) r = make_res(ak, '0);
        else if (!bf) r = make_res(bk, '0);
        else r = clamp(a + b);
      end
      CMD_SUB: begin
        if (!af && !bf) r = (ak != bk) ? make_res(ak, '0) : make_err(ERR_INDET);
        else if (!af) r = make_res(ak, '0);
        else if (!bf) r = make_res(bk == KIND_POS ? KIND_NEG : KIND_POS, '0);
        else r = clamp(a - b);
      end
      CMD_MUL: begin
        if (!af || !bf) begin
          if ((af && a == 0) || (bf && b == 0)) r = make_err(ERR_INDET);
          else r = make_res(is_neg(ak, a) != is_neg(bk, b) ? KIND_NEG : KIND_POS, '0);
        end else r = clamp(a * b);
      end
      CMD_DIV: begin
        if (bf && b == 0) r = make_err(ERR_DIVZ);
        else if (!af) begin
          if (!bf) r = make_err(ERR_INDET);
          else r = make_res(is_neg(ak, a) != is_neg(bk, b) ? KIND_NEG : KIND_POS, '0);
        end else if (a == 0 || !bf) r = make_res(KIND_FIN, '0);
        else r = clamp(a / b);
      end
      CMD_REM: begin
        if (bf && b == 0) r = make_err(ERR_DIVZ);
        else if (af && a == 0) r = make_res(KIND_FIN, '0);
        else if (af && !bf) r = make_res(KIND_FIN, av);
        else if (bf && (b == 1 || b == -1)) r = make_res(KIND_FIN, '0);
        else if (!af) r = make_err(ERR_INDET);
        else r = clamp(a % b);
      end
      CMD_NEG: begin
        if (!af) r = make_res(ak == KIND_POS ? KIND_NEG : KIND_POS, '0);
        else r = clamp(-a);
      end
      CMD_INC: r = af ? clamp(a + 1) : make_res(ak, '0);
      CMD_DEC: r = af ? clamp(a - 1) : make_res(ak, '0);
      CMD_CMP: begin
        if (af && bf) begin
          r.ord = 1'b1;
          r.lt  = a < b;
          r.eq  = a == b;
          r.gt  = a > b;
        end
      end
      default: r = make_err(ERR_NONE);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Offer one request, with random idle cycles ahead of it
  task automatic send_request(logic [3:0] cmd, logic [1:0] ak, logic [31:0] av,
                              logic [1:0] bk, logic [31:0] bv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {bk, ak, cmd};
    in_tdata  <= {bv, av};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(alu_predict(cmd, ak, av, bk, bv));
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(7))
      0: return VMAX;
      1: return VMIN;
      2: return 32'(int'($urandom_range(6)) - 3);
      3: return $urandom_range(65535);
      4: return -$urandom_range(65535);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] rand_kind();
    int p;
    p = $urandom_range(99);
    if (p < 70) return KIND_FIN;
    if (p < 83) return KIND_POS;
    if (p < 96) return KIND_NEG;
    return KIND_BAD;
  endfunction

  task automatic add_row(logic [3:0] cmd, logic [1:0] ak, logic [31:0] av,
                         logic [1:0] bk, logic [31:0] bv, bit known, alu_result_t res);
    alu_row_t r;
    r.cmd = cmd; r.ak = ak; r.av = av; r.bk = bk; r.bv = bv;
    r.known = known; r.res = res;
    rows.push_back(r);
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], '0);
      end else begin
        want = expected_q.pop_front();
        if (out_tuser[1:0] !== want.kind) report_mismatch("kind", out_tuser[1:0], want.kind);
        if (out_tdata[31:0] !== want.value) report_mismatch("value", out_tdata[31:0], want.value);
        if (out_tuser[3:2] !== want.err) report_mismatch("error", out_tuser[3:2], want.err);
        if (out_tdata[35:32] !== {want.gt, want.eq, want.lt, want.ord})
          report_mismatch("flags", out_tdata[35:32], {want.gt, want.eq, want.lt, want.ord});
      end
    end
  end

  // Drive ready with random stalls, or hold it low during a long hold-off
  always @(negedge clk) begin
    if (recv_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    alu_result_t none;
    none = '{default: '0};
    errors = 0; recv_hold = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0; out_tready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows: extremes, infinities, errors and every command
    add_row(CMD_ADD, KIND_FIN, VMAX, KIND_FIN, 1, 1, make_res(KIND_POS, 0));
    add_row(CMD_ADD, KIND_FIN, VMIN, KIND_FIN, -1, 1, make_res(KIND_NEG, 0));
    add_row(CMD_ADD, KIND_POS, 0, KIND_NEG, 0, 1, make_err(ERR_INDET));
    add_row(CMD_SUB, KIND_POS, 0, KIND_POS, 0, 1, make_err(ERR_INDET));
    add_row(CMD_SUB, KIND_FIN, 5, KIND_NEG, 0, 1, make_res(KIND_POS, 0));
    add_row(CMD_SUB, KIND_FIN, VMIN, KIND_FIN, VMAX, 0, none);
    add_row(CMD_MUL, KIND_POS, 0, KIND_FIN, 0, 1, make_err(ERR_INDET));
    add_row(CMD_MUL, KIND_FIN, VMIN, KIND_FIN, -1, 1, make_res(KIND_POS, 0));
    add_row(CMD_MUL, KIND_FIN, 32'h10000, KIND_FIN, 32'hffff8000, 0, none);
    add_row(CMD_MUL, KIND_NEG, 0, KIND_FIN, -7, 1, make_res(KIND_POS, 0));
    add_row(CMD_DIV, KIND_FIN, 9, KIND_FIN, 0, 1, make_err(ERR_DIVZ));
    add_row(CMD_DIV, KIND_POS, 0, KIND_FIN, 0, 1, make_err(ERR_DIVZ));
    add_row(CMD_DIV, KIND_FIN, VMIN, KIND_FIN, -1, 1, make_res(KIND_POS, 0));
    add_row(CMD_DIV, KIND_POS, 0, KIND_NEG, 0, 1, make_err(ERR_INDET));
    add_row(CMD_DIV, KIND_FIN, -7, KIND_FIN, 2, 0, none);
    add_row(CMD_REM, KIND_NEG, 0, KIND_FIN, -1, 1, make_res(KIND_FIN, 0));
    add_row(CMD_REM, KIND_POS, 0, KIND_FIN, 3, 1, make_err(ERR_INDET));
    add_row(CMD_REM, KIND_FIN, -7, KIND_POS, 0, 1, make_res(KIND_FIN, -7));
    add_row(CMD_REM, KIND_FIN, VMIN, KIND_FIN, 3, 0, none);
    add_row(CMD_NEG, KIND_FIN, VMIN, KIND_FIN, 0, 1, make_res(KIND_POS, 0));
    add_row(CMD_INC, KIND_FIN, VMAX, KIND_FIN, 0, 1, make_res(KIND_POS, 0));
    add_row(CMD_DEC, KIND_FIN, VMIN, KIND_FIN, 0, 1, make_res(KIND_NEG, 0));
    add_row(CMD_CMP, KIND_FIN, VMIN, KIND_FIN, VMAX, 0, none);
    add_row(CMD_CMP, KIND_POS, 0, KIND_FIN, 0, 1, none);
    add_row(CMD_ADD, KIND_BAD, 0, KIND_FIN, 1, 1, make_err(ERR_INDET));
    add_row(4'd15, KIND_BAD, 32'hffffffff, KIND_BAD, 32'hffffffff, 1, none);

    foreach (rows[i]) begin
      if (rows[i].known &&
          alu_predict(rows[i].cmd, rows[i].ak, rows[i].av, rows[i].bk, rows[i].bv)
          != rows[i].res) begin
        $display("directed row %0d disagrees with prediction", i);
        errors++;
      end
      send_request(rows[i].cmd, rows[i].ak, rows[i].av, rows[i].bk, rows[i].bv);
    end
    wait_drained();

    // Long receiver hold-off so the queue fills and input stalls
    fork
      begin
        recv_hold = 1;
        repeat (200) @(negedge clk);
        recv_hold = 0;
      end
      for (int i = 0; i < 60; i++)
        send_request(CMD_MUL, KIND_FIN, rand_value(), KIND_FIN, rand_value());
    join
    wait_drained();

    // Random phases with changing idle mixes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 22 : 0;
      for (int i = 0; i < 580; i++)
        send_request(($urandom_range(99) < 3) ? 4'($urandom_range(15, 9))
                                               : 4'($urandom_range(8)),
                     rand_kind(), rand_value(), rand_kind(), rand_value());
      wait_drained();
    end

    repeat (60) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
